// ===== rtl/dpwsq_pkg.sv =====
// Shared widths, register indexes, reset values and helpers for the DPW pulse oscillator.
package dpwsq_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int PHASE_W    = 24;
   localparam int INC_W      = 23;
   localparam int GAIN_W     = 24;
   localparam int DELAY_W    = 12;
   localparam int AMP_W      = 16;
   localparam int PARA_W     = 25;
   localparam int MUL_W      = 27;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_INC = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFF_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE = 3'd3;

   localparam logic [INC_W-1:0]   RST_PHASE_INC = 23'd153791;
   localparam logic [GAIN_W-1:0]  RST_DIFF_GAIN = 24'd111698;
   localparam logic [DELAY_W-1:0] RST_DELAY     = 12'd54;
   localparam logic [AMP_W-1:0]   RST_AMPLITUDE = 16'd16384;

   localparam logic signed [PROD_W-1:0] SAT_HI = 54'sd8388607;
   localparam logic signed [PROD_W-1:0] SAT_LO = -54'sd8388608;

   // Bipolar offset: one in Q2.24
   localparam logic signed [MUL_W-1:0] PHASE_ONE = 27'sd16777216;

   typedef struct packed {
      logic fwd;     // tap address equals the entry just written
      logic valid;   // tap entry has been written since reset
   } tap_flags_type;

   function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [PROD_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[SAMPLE_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[SAMPLE_W-1:0];
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/dpw_bandlimited_square_osc_core.sv =====
// DPW pulse oscillator: phase, parabola, saw delay line and output scaling around one multiplier.
// A tick passes through the gain, saw, mix and output steps before its result enters the output register.
// The shared 27x27 multiplier runs three times per tick (square, gain, amplitude), with the delay
// line read in between; a new tick is taken in the output step of the last one once the output is free.
// Reset (synchronous) clears phase, parabola history, write pointer and registers to defaults.
// The delay line is never cleared; a wrap flag marks entries not yet written, which read as zero.
module dpw_bandlimited_square_osc_core
   import dpwsq_pkg::*;
#(
   parameter int DELAY_DEPTH = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_advance,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_W-1:0]    rsp_sample_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic        [CSR_IDX_W-1:0]   csr_index,
   input  logic        [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(DELAY_DEPTH);
   localparam int MW = (AW + 4 > DELAY_W) ? AW + 4 : DELAY_W;
   localparam logic [AW-1:0] WP_LAST = AW'(DELAY_DEPTH - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_GAIN = 3'd1;
   localparam logic [2:0] S_SAW  = 3'd2;
   localparam logic [2:0] S_MIX  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   // Tap address: (wp - delay mod depth) mod depth, reduced by restoring subtraction.
   function automatic logic [AW-1:0] tap_addr(input logic [AW-1:0] wp,
                                              input logic [DELAY_W-1:0] dly);
      logic [MW-1:0] r;
      logic [MW-1:0] step;
      logic [MW-1:0] w;
      logic [AW-1:0] a;
      r = MW'(dly);
      for (int k = 3; k >= 0; k--) begin
         step = MW'(DELAY_DEPTH) << k;
         if (r >= step) begin
            r = r - step;
         end
      end
      w = MW'(wp);
      if (w >= r) begin
         a = AW'(w - r);
      end else begin
         a = AW'(w + MW'(DELAY_DEPTH) - r);
      end
      return a;
   endfunction

   logic [2:0]                  state_ff, state_in;
   logic [INC_W-1:0]            inc_ff;
   logic [GAIN_W-1:0]           gain_ff;
   logic [DELAY_W-1:0]          delay_ff;
   logic [AMP_W-1:0]            amp_ff;
   logic [PHASE_W-1:0]          phase_ff, phase_in;
   logic [PARA_W-1:0]           prev_ff, para_in;
   logic [AW-1:0]               wp_ff;
   logic                        full_ff;
   logic [AW-1:0]               rd_ff;
   tap_flags_type               flags_ff;
   logic signed [SAMPLE_W-1:0]  saw_ff, saw_in;
   logic signed [SAMPLE_W-1:0]  rd_data_ff;
   logic signed [SAMPLE_W-1:0]  delayed;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [MUL_W-1:0]     mul_a, mul_b, bip;
   logic                        rsp_valid_ff;
   logic signed [SAMPLE_W-1:0]  rsp_sample_ff;
   logic                        out_free, accept, accept_adv, prod_en;

   logic signed [SAMPLE_W-1:0]  delay_mem [DELAY_DEPTH];

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == S_IDLE) || ((state_ff == S_OUT) && out_free));
   assign accept     = req_valid && !req_stall;
   assign accept_adv = accept && req_advance;
   assign csr_ready  = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   assign phase_in = phase_ff + PHASE_W'(inc_ff);
   assign bip      = $signed({2'b00, phase_in, 1'b0}) - PHASE_ONE;
   assign para_in  = prod_ff[PARA_W+PHASE_W-1:PHASE_W];
   assign saw_in   = sat24(prod_ff >>> 16);
   assign prod_in  = mul_a * mul_b;
   assign prod_en  = accept_adv || (state_ff == S_GAIN) || (state_ff == S_MIX);

   always_comb begin
      if (flags_ff.fwd) begin
         delayed = saw_ff;
      end else if (flags_ff.valid) begin
         delayed = rd_data_ff;
      end else begin
         delayed = '0;
      end
   end

   // Shared multiplier operand select
   always_comb begin
      case (state_ff)
         S_GAIN: begin
            mul_a = $signed({3'b000, gain_ff});
            mul_b = $signed({2'b00, para_in}) - $signed({2'b00, prev_ff});
         end
         S_MIX: begin
            mul_a = $signed({11'd0, amp_ff});
            mul_b = MUL_W'(saw_ff) - MUL_W'(delayed);
         end
         default: begin
            mul_a = bip;
            mul_b = bip;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept_adv) begin
               state_in = S_GAIN;
            end
         end
         S_GAIN: state_in = S_SAW;
         S_SAW:  state_in = S_MIX;
         S_MIX:  state_in = S_OUT;
         S_OUT: begin
            if (accept_adv) begin
               state_in = S_GAIN;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         inc_ff       <= RST_PHASE_INC;
         gain_ff      <= RST_DIFF_GAIN;
         delay_ff     <= RST_DELAY;
         amp_ff       <= RST_AMPLITUDE;
         phase_ff     <= '0;
         prev_ff      <= '0;
         wp_ff        <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PHASE_INC: inc_ff   <= csr_wdata[INC_W-1:0];
               CSR_DIFF_GAIN: gain_ff  <= csr_wdata[GAIN_W-1:0];
               CSR_DELAY:     delay_ff <= csr_wdata[DELAY_W-1:0];
               CSR_AMPLITUDE: amp_ff   <= csr_wdata[AMP_W-1:0];
               default: ;
            endcase
         end
         if (accept_adv) begin
            phase_ff <= phase_in;
         end
         if (state_ff == S_GAIN) begin
            prev_ff <= para_in;
         end
         if (state_ff == S_SAW) begin
            wp_ff <= (wp_ff == WP_LAST) ? '0 : wp_ff + AW'(1);
            if (wp_ff == WP_LAST) begin
               full_ff <= 1'b1;
            end
         end
         if ((state_ff == S_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (prod_en) begin
         prod_ff <= prod_in;
      end
      if (state_ff == S_GAIN) begin
         rd_ff <= tap_addr(wp_ff, delay_ff);
      end
      if (state_ff == S_SAW) begin
         saw_ff         <= saw_in;
         flags_ff.fwd   <= (rd_ff == wp_ff);
         flags_ff.valid <= full_ff || (rd_ff <= wp_ff);
      end
      if ((state_ff == S_OUT) && out_free) begin
         rsp_sample_ff <= sat24(prod_ff >>> 15);
      end
   end

   // Delay line: write the new saw and read the tap in the same cycle
   always_ff @(posedge clock) begin
      if (state_ff == S_SAW) begin
         delay_mem[wp_ff] <= saw_in;
         rd_data_ff       <= delay_mem[rd_ff];
      end
   end

   a_wp_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SAW) |=>
         (wp_ff == (($past(wp_ff) == WP_LAST) ? '0 : $past(wp_ff) + AW'(1))))
      else $error("write pointer did not advance by one");

   a_zero_delay: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_MIX) && flags_ff.fwd) |=> (prod_ff == '0))
      else $error("zero delay tap did not cancel the saw");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("result raised outside the output step");

endmodule
